// ===== hdl/lsh3_pkg.sv =====
// Shared types, constants and arithmetic helpers of the 3x3 Laplacian sharpening core.
`default_nettype none

package lsh3_pkg;

    // Field and register widths
    localparam int PIX_W         = 8;
    localparam int IMG_W_W       = 11;
    localparam int IMG_H_W       = 12;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 12;
    localparam int IN_LINE_W     = 16;
    localparam int ACC_W         = 13;

    // Defaults
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int WIDTH_RST     = 640;
    localparam int HEIGHT_RST    = 480;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Input item kinds (carried on s_tuser)
    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_t;

    // Control that travels with an item from the counter stage to the filter stage
    typedef struct packed {
        logic wr;     // item lies in the frame and updates the line stores
        logic emit;   // item completes a window and produces a result
        logic up;     // row above the centre is inside the frame
        logic down;   // row below the centre is inside the frame
        logic left;   // column left of the centre is inside the frame
        logic right;  // column right of the centre is inside the frame
        logic eol;    // result closes an output line
        logic eof;    // result closes the frame
    } s1_ctl_t;

    // Centre minus one neighbour, or nothing when the neighbour is off the frame
    function automatic logic signed [ACC_W-1:0] nb_term(
        input logic             en,
        input logic [PIX_W-1:0] cen,
        input logic [PIX_W-1:0] nb
    );
        logic signed [ACC_W-1:0] diff;
        diff = $signed({{(ACC_W-PIX_W){1'b0}}, cen}) - $signed({{(ACC_W-PIX_W){1'b0}}, nb});
        return en ? diff : '0;
    endfunction

    // Saturate the filter sum to an 8-bit sample
    function automatic logic [PIX_W-1:0] clamp_pixel(input logic signed [ACC_W-1:0] acc);
        logic [PIX_W-1:0] res;
        if (acc < 0) begin
            res = '0;
        end else if (acc > $signed(ACC_W'(255))) begin
            res = '1;
        end else begin
            res = acc[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/laplacian_sharpen_3x3_core.sv =====
// Top level of the 3x3 Laplacian sharpening core: counters, line stores, window and filter.
//
// Usage
//   Input stream s_*: one item per transfer. s_tdata carries the 8-bit luma sample,
//   s_tuser the command (pixel or drain). Pixels arrive in raster order; after the
//   last pixel of a frame, drain items push out the results still pending.
//   Result stream m_*: m_tdata is the sharpened sample, m_tlast marks the last pixel
//   of an output line, m_tuser the last pixel of the frame. Results lag the input
//   stream by one line plus one pixel; items that complete no window give no result.
//   Configuration: cfg_we writes cfg_wdata into the register at cfg_addr (0 = image
//   width, 1 = image height); write only while the core is idle.
// Timing
//   One item per clock sustained while the result stream is not stalled. The item that
//   completes a window is registered into the filter stage with the counters and the
//   line store read; the window and the 3x3 sum then go into the output register.
//   The two line stores are MAX_WIDTH x 8 memories, read once per item and written once per in-frame item.
// Reset and stalls
//   aresetn (synchronous) returns width/height to 640/480 and clears counters and
//   pipeline; line stores keep their contents. When m_tready is low the filter stage
//   holds one item and the output register another; s_tready then drops.
`default_nettype none

module laplacian_sharpen_3x3_core
    import lsh3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel_in
    input  wire logic                  s_tuser,   // [0] command
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [PIX_W-1:0]           m_tdata,   // [7:0] pixel_out
    output logic                       m_tlast,   // end_of_line
    output logic                       m_tuser    // [0] end_of_frame
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW    = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;
    localparam int WIDTH_RST_EFF = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
    localparam logic [COL_W-1:0]   W_M1_RST = COL_W'(WIDTH_RST_EFF - 1);
    localparam logic [IMG_H_W-1:0] H_M1_RST = IMG_H_W'(HEIGHT_RST - 1);

    // Saturating line count step
    function automatic logic [IN_LINE_W-1:0] line_inc(input logic [IN_LINE_W-1:0] v);
        return (v == '1) ? v : v + IN_LINE_W'(1);
    endfunction

    // Effective geometry, held as last index
    logic [COL_W-1:0]    w_m1_reg;
    logic [IMG_H_W-1:0]  h_m1_reg;

    // Position counters
    logic [COL_W-1:0]     in_col_reg, in_col_next;
    logic [IN_LINE_W-1:0] in_line_reg, in_line_next;
    logic [COL_W-1:0]     out_col_reg, out_col_next;
    logic [IMG_H_W-1:0]   out_line_reg, out_line_next;

    // Filter stage
    logic                 s1_valid_reg;
    s1_ctl_t              s1_ctl_reg;
    logic [COL_W-1:0]     s1_c_reg;
    logic [PIX_W-1:0]     s1_bot_reg;
    logic                 fwd_reg;
    logic [PIX_W-1:0]     fwd_mid_reg;
    logic [PIX_W-1:0]     rd_top_reg, rd_mid_reg;

    // Window: left column (a) and centre column (b)
    logic [PIX_W-1:0]     a_top_reg, a_mid_reg, a_bot_reg;
    logic [PIX_W-1:0]     b_top_reg, b_mid_reg, b_bot_reg;

    // Output register
    logic                 m_valid_reg;
    logic [PIX_W-1:0]     m_pix_reg;
    logic                 m_eol_reg, m_eof_reg;

    // Line stores
    logic [PIX_W-1:0] above_mem     [MAX_WIDTH];
    logic [PIX_W-1:0] two_above_mem [MAX_WIDTH];

    // ---------------------------------------------------------------
    // Configuration decode: clamp to the usable range on write
    // ---------------------------------------------------------------
    logic [EW-1:0]      cfg_w, cfg_w_eff, cfg_w_dec;
    logic [COL_W-1:0]   cfg_w_m1;
    logic [IMG_H_W-1:0] cfg_h, cfg_h_m1;

    always_comb begin
        cfg_w = EW'(cfg_wdata[IMG_W_W-1:0]);
        if (cfg_w == '0) begin
            cfg_w_eff = EW'(1);
        end else if (cfg_w > EW'(MAX_WIDTH)) begin
            cfg_w_eff = EW'(MAX_WIDTH);
        end else begin
            cfg_w_eff = cfg_w;
        end
        cfg_w_dec = cfg_w_eff - EW'(1);
        cfg_w_m1  = cfg_w_dec[COL_W-1:0];
        cfg_h     = cfg_wdata[IMG_H_W-1:0];
        cfg_h_m1  = (cfg_h == '0) ? '0 : cfg_h - IMG_H_W'(1);
    end

    // ---------------------------------------------------------------
    // Counter stage: position of the item and what it produces
    // ---------------------------------------------------------------
    logic                 s_accept, s1_adv, out_free, m_load;
    logic                 clr, wrap, in_frame, drain_hold, emit1, emit2, col_last;
    logic [COL_W-1:0]     col_a, c0, oc;
    logic [IN_LINE_W-1:0] line_a, line_b;
    logic [IMG_H_W-1:0]   ol;
    s1_ctl_t              ctl;

    always_comb begin
        // frame abandoned after a height change
        clr    = out_line_reg > h_m1_reg;
        col_a  = clr ? '0 : in_col_reg;
        line_a = clr ? '0 : in_line_reg;
        oc     = clr ? '0 : out_col_reg;
        ol     = clr ? '0 : out_line_reg;

        // line wrap left over from a width change
        wrap   = col_a > w_m1_reg;
        c0     = wrap ? '0 : col_a;
        line_b = wrap ? line_inc(line_a) : line_a;

        in_frame   = line_b <= IN_LINE_W'(h_m1_reg);
        drain_hold = (cmd_t'(s_tuser) == CMD_DRAIN) && in_frame;

        // first column closes the previous line's last window
        emit2    = (c0 == '0) && (line_b >= IN_LINE_W'(2));
        emit1    = (c0 != '0) && (line_b != '0);
        col_last = c0 == w_m1_reg;

        ctl.wr    = in_frame;
        ctl.emit  = emit1 || emit2;
        ctl.eol   = oc >= w_m1_reg;
        ctl.eof   = ctl.eol && (ol >= h_m1_reg);
        ctl.up    = ol != '0;
        ctl.down  = ol < h_m1_reg;
        ctl.left  = oc != '0;
        ctl.right = !ctl.eol && !emit2;

        // next positions
        in_col_next   = col_last ? '0 : c0 + COL_W'(1);
        in_line_next  = col_last ? line_inc(line_b) : line_b;
        out_col_next  = oc;
        out_line_next = ol;
        if (drain_hold) begin
            in_col_next  = c0;
            in_line_next = line_b;
        end else if (ctl.emit) begin
            if (ctl.eof) begin
                in_col_next   = '0;
                in_line_next  = '0;
                out_col_next  = '0;
                out_line_next = '0;
            end else if (ctl.eol) begin
                out_col_next  = '0;
                out_line_next = ol + IMG_H_W'(1);
            end else begin
                out_col_next  = oc + COL_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    assign out_free = !m_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && (!s1_ctl_reg.emit || out_free);
    assign m_load   = s1_adv && s1_ctl_reg.emit;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Filter stage: new column, window and 3x3 sum
    // ---------------------------------------------------------------
    logic [PIX_W-1:0]        n_top, n_mid, n_bot;
    logic signed [ACC_W-1:0] acc;
    logic [PIX_W-1:0]        pix_res;

    always_comb begin
        // the previous item may have just written the same upper-store entry
        n_top = fwd_reg ? fwd_mid_reg : rd_top_reg;
        n_mid = rd_mid_reg;
        n_bot = s1_bot_reg;

        acc = $signed({{(ACC_W-PIX_W){1'b0}}, b_mid_reg})
            + nb_term(s1_ctl_reg.up && s1_ctl_reg.left,    b_mid_reg, a_top_reg)
            + nb_term(s1_ctl_reg.up,                       b_mid_reg, b_top_reg)
            + nb_term(s1_ctl_reg.up && s1_ctl_reg.right,   b_mid_reg, n_top)
            + nb_term(s1_ctl_reg.left,                     b_mid_reg, a_mid_reg)
            + nb_term(s1_ctl_reg.right,                    b_mid_reg, n_mid)
            + nb_term(s1_ctl_reg.down && s1_ctl_reg.left,  b_mid_reg, a_bot_reg)
            + nb_term(s1_ctl_reg.down,                     b_mid_reg, b_bot_reg)
            + nb_term(s1_ctl_reg.down && s1_ctl_reg.right, b_mid_reg, n_bot);
        pix_res = clamp_pixel(acc);
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_m1_reg     <= W_M1_RST;
            h_m1_reg     <= H_M1_RST;
            in_col_reg   <= '0;
            in_line_reg  <= '0;
            out_col_reg  <= '0;
            out_line_reg <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_IMAGE_WIDTH:  w_m1_reg <= cfg_w_m1;
                    REG_IMAGE_HEIGHT: h_m1_reg <= cfg_h_m1;
                    default: ;
                endcase
            end
            if (s_accept) begin
                in_col_reg   <= in_col_next;
                in_line_reg  <= in_line_next;
                out_col_reg  <= out_col_next;
                out_line_reg <= out_line_next;
                s1_valid_reg <= !drain_hold;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Pipeline payload
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_ctl_reg  <= ctl;
            s1_c_reg    <= c0;
            s1_bot_reg  <= in_frame ? s_tdata : '0;
            fwd_reg     <= s1_valid_reg && s1_ctl_reg.wr && (s1_c_reg == c0);
            fwd_mid_reg <= rd_mid_reg;
        end
        if (s1_adv) begin
            a_top_reg <= b_top_reg;
            a_mid_reg <= b_mid_reg;
            a_bot_reg <= b_bot_reg;
            b_top_reg <= n_top;
            b_mid_reg <= n_mid;
            b_bot_reg <= n_bot;
        end
        if (m_load) begin
            m_pix_reg <= pix_res;
            m_eol_reg <= s1_ctl_reg.eol;
            m_eof_reg <= s1_ctl_reg.eof;
        end
    end

    // ---------------------------------------------------------------
    // Line stores: the upper one is written as the item leaves the filter stage, from the read of the lower
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_mid_reg <= above_mem[c0];
            if (in_frame && !drain_hold) begin
                above_mem[c0] <= s_tdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_top_reg <= two_above_mem[c0];
        end
        if (s1_adv && s1_ctl_reg.wr) begin
            two_above_mem[s1_c_reg] <= rd_mid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pix_reg;
    assign m_tlast  = m_eol_reg;
    assign m_tuser  = m_eof_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_eof_is_eol: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of frame without end of line");

    a_eof_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !drain_hold && ctl.emit && ctl.eof |=>
            in_col_reg == '0 && in_line_reg == '0 && out_line_reg == '0)
        else $error("counters not cleared after end of frame");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_ctl_reg.emit && m_valid_reg && !m_tready |=>
            s1_valid_reg && $stable(s1_c_reg))
        else $error("filter stage item lost during output stall");

    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> s1_valid_reg && m_valid_reg && !m_tready)
        else $error("input stalled without a blocked result");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !(s1_valid_reg && s1_ctl_reg.emit) |=> !m_tvalid)
        else $error("result appeared without a filtered item");

endmodule

`default_nettype wire

// ===== bench/laplacian_sharpen_3x3_core_tb.sv =====
// Self-checking bench for the 3x3 Laplacian sharpening core: stream stimulus, scoreboard, checks.
module laplacian_sharpen_3x3_core_tb;
    import lsh3_pkg::*;

    // One sharpened output sample as the result stream carries it
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             eol;
        logic             eof;
    } sharp_result_t;

    // Tracks frame position, line stores and window; predicts every sharpened sample
    class sharpen_scoreboard;
        int unsigned   width_reg;
        int unsigned   height_reg;
        logic [7:0]    line_above [MAX_WIDTH_DEF];
        logic [7:0]    line_two_above [MAX_WIDTH_DEF];
        logic [7:0]    win [9];
        int unsigned   in_col;
        int unsigned   in_line;
        int unsigned   out_col;
        int unsigned   out_line;
        sharp_result_t expected_pixels [$];
        int            errors;
        int            taken;
        int            ignored;
        int            checked;
        int            frames;

        function new();
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            foreach (line_above[i]) begin
                line_above[i]     = '0;
                line_two_above[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            clear_counters();
            errors  = 0;
            taken   = 0;
            ignored = 0;
            checked = 0;
            frames  = 0;
        endfunction

        function void clear_counters();
            in_col   = 0;
            in_line  = 0;
            out_col  = 0;
            out_line = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_IMAGE_WIDTH) width_reg = val[IMG_W_W-1:0];
            else height_reg = val[IMG_H_W-1:0];
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // True while the next item would still land inside the frame
        function bit wants_pixel();
            int unsigned line;
            if (out_line >= eff_height()) return 1'b1;
            line = in_line;
            if (in_col >= eff_width()) line++;
            return line < eff_height();
        endfunction

        function bit frame_idle();
            return in_col == 0 && in_line == 0 && out_col == 0 && out_line == 0;
        endfunction

        // Centre plus the centre-minus-neighbour terms around window column k; off-frame neighbours add nothing
        function logic [7:0] filter_window(int unsigned k, int unsigned w, int unsigned h);
            int acc;
            int cen;
            bit up, down, left, right, row_in, col_in;
            cen   = win[3 + k];
            acc   = cen;
            up    = out_line >= 1;
            down  = out_line + 1 < h;
            left  = out_col >= 1;
            right = (out_col + 1 < w) && (k < 2);
            for (int r = 0; r < 3; r++) begin
                row_in = (r == 0) ? up : (r == 2) ? down : 1'b1;
                for (int q = 0; q < 3; q++) begin
                    col_in = (q == 0) ? left : (q == 2) ? right : 1'b1;
                    if (!(r == 1 && q == 1) && row_in && col_in)
                        acc += cen - int'(win[r * 3 + k + q - 1]);
                end
            end
            if (acc < 0) acc = 0;
            if (acc > 255) acc = 255;
            return acc[7:0];
        endfunction

        // Called on every accepted input transfer
        function void note_input(cmd_t cmd, logic [7:0] pix);
            int unsigned   w, h, c;
            logic [7:0]    top, mid, bot, value;
            bit            in_frame, emit;
            sharp_result_t res;
            w     = eff_width();
            h     = eff_height();
            value = '0;
            emit  = 1'b0;
            if (out_line >= h) clear_counters();
            if (in_col >= w) begin
                in_col = 0;
                in_line++;
            end
            in_frame = in_line < h;
            if (cmd == CMD_DRAIN && in_frame) begin
                ignored++;
                return;
            end
            taken++;
            c   = in_col;
            top = line_two_above[c];
            mid = line_above[c];
            bot = in_frame ? pix : 8'h00;
            if (in_frame) begin
                line_two_above[c] = mid;
                line_above[c]     = pix;
            end
            // last column of the previous line finishes when a new line starts
            if (c == 0 && in_line >= 2) begin
                value = filter_window(2, w, h);
                emit  = 1'b1;
            end
            win[0] = win[1]; win[1] = win[2]; win[2] = top;
            win[3] = win[4]; win[4] = win[5]; win[5] = mid;
            win[6] = win[7]; win[7] = win[8]; win[8] = bot;
            if (c >= 1 && in_line >= 1) begin
                value = filter_window(1, w, h);
                emit  = 1'b1;
            end
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                if (in_line < 32'hFFFF) in_line++;
            end
            if (emit && out_line < h) begin
                res.pixel = value;
                res.eol   = out_col + 1 >= w;
                res.eof   = res.eol && (out_line + 1 >= h);
                expected_pixels = {expected_pixels, res};
                if (res.eof) begin
                    clear_counters();
                    frames++;
                end else if (res.eol) begin
                    out_col = 0;
                    out_line++;
                end else begin
                    out_col++;
                end
            end
        endfunction

        // Called on every accepted result transfer
        function void check_result(logic [7:0] pix, logic eol, logic eof);
            sharp_result_t want;
            if (expected_pixels.size() == 0) begin
                errors++;
                $error("unexpected result: pixel_out %0d end_of_line %0b end_of_frame %0b",
                       pix, eol, eof);
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            if (pix !== want.pixel) begin
                errors++;
                $error("pixel_out: expected %0d, actual %0d", want.pixel, pix);
            end
            if (eol !== want.eol) begin
                errors++;
                $error("end_of_line: expected %0b, actual %0b", want.eol, eol);
            end
            if (eof !== want.eof) begin
                errors++;
                $error("end_of_frame: expected %0b, actual %0b", want.eof, eof);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata;   // [7:0] pixel_in
    logic                  s_tuser;   // [0] command
    logic                  m_tvalid;
    logic                  m_tready;
    logic [PIX_W-1:0]      m_tdata;   // [7:0] pixel_out
    logic                  m_tlast;   // end_of_line
    logic                  m_tuser;   // [0] end_of_frame

    sharpen_scoreboard sb;
    bit tx_idles;
    bit rx_idles;
    int hold_req;
    int settings;

    laplacian_sharpen_3x3_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Transfers on both channels, seen at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
            if (s_tvalid && s_tready) sb.note_input(cmd_t'(s_tuser), s_tdata);
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_pixel(int mode, int idx);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 1) return (idx % 2) ? 8'hFF : 8'h00;
        if (mode == 2) return (idx % 2) ? 8'h00 : 8'hFF;
        if (r < 15) return 8'h00;
        if (r < 30) return 8'hFF;
        return 8'($urandom);
    endfunction

    // Result side backpressure: random stalls, and a stall counted down from each hold request
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (rx_idles && $urandom_range(0, 99) < 25) begin
                m_tready   = 1'b0;
                stall_left = (($urandom_range(0, 99) < 88) ? $urandom_range(1, 3)
                                                           : $urandom_range(8, 40)) - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // All stimulus tasks start and end just after a falling edge
    task automatic send_item(input cmd_t cmd, input logic [7:0] pix);
        int gap;
        gap = tx_idles ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = pix;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_we = 1'b0;
        @(negedge aclk);
    endtask

    // Hold the input until every result is out and the pipeline has emptied
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // One frame: pixels until the frame is full, then drains until the last result.
    // stop_after > 0 leaves the frame open after that many pixels.
    task automatic run_frame(input int mode, input int drain_noise, input int pixel_as_drain,
                             input int stop_after);
        int idx;
        idx = 0;
        while (sb.wants_pixel() && (stop_after == 0 || idx < stop_after)) begin
            if ($urandom_range(0, 99) < drain_noise) send_item(CMD_DRAIN, 8'($urandom));
            send_item(CMD_PIXEL, pick_pixel(mode, idx));
            idx++;
        end
        if (stop_after == 0) begin
            while (!sb.frame_idle()) begin
                if ($urandom_range(0, 99) < pixel_as_drain) send_item(CMD_PIXEL, 8'($urandom));
                else send_item(CMD_DRAIN, 8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        int base;
        int frame_no;
        int r;
        int guard;
        logic [CFG_DATA_W-1:0] w_val;
        logic [CFG_DATA_W-1:0] h_val;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_IMAGE_WIDTH;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_PIXEL;
        tx_idles  = 1'b1;
        rx_idles  = 1'b1;
        hold_req  = 0;
        settings  = 0;
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Checkerboards drive the sum to both clamps; drains inside the frame are
        // ignored, pixels after the frame act as drains, a drain after it is ignored
        write_reg(REG_IMAGE_WIDTH, 12'd3);
        write_reg(REG_IMAGE_HEIGHT, 12'd3);
        settings++;
        run_frame(1, 100, 100, 0);
        run_frame(2, 0, 0, 0);
        send_item(CMD_DRAIN, 8'hA5);
        wait_idle();

        // Zero width and height behave as one
        write_reg(REG_IMAGE_WIDTH, 12'd0);
        write_reg(REG_IMAGE_HEIGHT, 12'd0);
        settings++;
        run_frame(0, 0, 50, 0);
        wait_idle();

        // Height cut below the current output line abandons the open frame
        write_reg(REG_IMAGE_WIDTH, 12'd4);
        write_reg(REG_IMAGE_HEIGHT, 12'd4);
        settings++;
        run_frame(0, 0, 0, 12);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 12'd1);
        settings++;
        run_frame(0, 0, 30, 0);
        wait_idle();

        // Width narrowed in the middle of a frame: counters wrap at the new width
        write_reg(REG_IMAGE_HEIGHT, 12'd4);
        settings++;
        run_frame(0, 0, 0, 6);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 12'd2);
        settings++;
        run_frame(0, 0, 30, 0);
        wait_idle();

        // Widest frame from an oversized width, kept to a single line
        write_reg(REG_IMAGE_WIDTH, 12'hFFF);
        write_reg(REG_IMAGE_HEIGHT, 12'd1);
        settings++;
        run_frame(0, 0, 30, 0);
        wait_idle();

        // Tallest frame, one column wide, cut short by a height change
        write_reg(REG_IMAGE_WIDTH, 12'd1);
        write_reg(REG_IMAGE_HEIGHT, 12'd4095);
        settings++;
        run_frame(0, 0, 0, 24);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 12'd1);
        settings++;
        run_frame(0, 0, 30, 0);
        wait_idle();

        // Random frames, mostly small, back to back or with a pause in between
        base     = sb.taken;
        frame_no = 0;
        while (sb.taken - base < 750) begin
            tx_idles = $urandom_range(0, 3) != 0;
            rx_idles = $urandom_range(0, 3) != 0;
            if (frame_no == 2) begin
                // long receiver hold while the sender keeps offering: input side backs up
                wait_idle();
                write_reg(REG_IMAGE_WIDTH, 12'd40);
                write_reg(REG_IMAGE_HEIGHT, 12'd6);
                settings++;
                tx_idles = 1'b0;
                hold_req = 300;
            end else if (frame_no == 0 || $urandom_range(0, 99) < 40) begin
                r = $urandom_range(0, 99);
                if (r < 3) w_val = '0;
                else if (r < 70) w_val = CFG_DATA_W'($urandom_range(1, 8));
                else if (r < 95) w_val = CFG_DATA_W'($urandom_range(9, 48));
                else w_val = CFG_DATA_W'($urandom_range(49, 160));
                if ($urandom_range(0, 9) == 0) w_val[IMG_W_W] = 1'b1;   // unused top bit
                r = $urandom_range(0, 99);
                if (r < 3) h_val = '0;
                else if (r < 80) h_val = CFG_DATA_W'($urandom_range(1, 6));
                else h_val = CFG_DATA_W'($urandom_range(7, 24));
                wait_idle();
                if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_WIDTH, w_val);
                if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_HEIGHT, h_val);
                settings++;
            end
            run_frame(0, 5, 30, 0);
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 3)) send_item(CMD_DRAIN, 8'($urandom));
            end
            frame_no++;
        end

        // Let the last results out
        s_tvalid = 1'b0;
        guard    = 0;
        while (sb.pending() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (20) @(negedge aclk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $error("%0d expected results never arrived", sb.pending());
        end

        $display("covered %0d frames over %0d geometry settings", sb.frames, settings);
        $display("%0d items taken, %0d ignored, %0d results checked",
                 sb.taken, sb.ignored, sb.checked);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #60000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
